### rtl/gamepad_to_pointer_motion_assert.svh
// Assertion macros for the gamepad-to-pointer block.
// Used by modules that declare clk and rst_n; no other dependencies.
`ifndef GAMEPAD_TO_POINTER_MOTION_ASSERT_SVH
`define GAMEPAD_TO_POINTER_MOTION_ASSERT_SVH

// cond implies prop in the same cycle
`define GTP_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gtp assertion failed");

// cond implies prop in the next cycle
`define GTP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gtp assertion failed");

`endif

### rtl/gtp_pkg.sv
// Package for the gamepad-to-pointer block: constants, types and datapath functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtp_pkg;

    localparam int PAD_BUTTONS   = 22;
    localparam int MOUSE_BUTTONS = 3;
    localparam int FRAC_BITS     = 8;

    localparam int BIND_W     = 5;
    localparam int MB_W       = 2;
    localparam int EV_CNT_W   = 2;
    localparam int STICK_W    = 8;
    localparam int COORD_W    = 10;
    localparam int POS_W      = COORD_W + FRAC_BITS;
    localparam int VEL_W      = 16;
    localparam int ACC_W      = 12;
    localparam int SPD_W      = 14;
    localparam int DZ_W       = 8;
    localparam int SCR_W      = 11;
    localparam int BINDS_W    = BIND_W * MOUSE_BUTTONS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int BTN_UP    = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_DOWN  = 4;
    localparam int BTN_LEFT  = 5;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // analog scale: q = ((p + 1) * RECIP) >> RECIP_SHIFT equals p / 127 for p < 2^21
    localparam int MAG_W       = 8;
    localparam int PROD_W      = 21;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 28;
    localparam int QUO_W       = 15;
    localparam logic [RECIP_W-1:0] RECIP        = 22'd2113665;
    localparam logic [STICK_W:0]   STICK_CENTRE = 9'd127;
    localparam logic [SCR_W-1:0]   MAX_SCREEN   = 11'd1024;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_MODE   = 3'd0;
    localparam cfg_idx_t CFG_ACCEL  = 3'd1;
    localparam cfg_idx_t CFG_SPEED  = 3'd2;
    localparam cfg_idx_t CFG_DEAD   = 3'd3;
    localparam cfg_idx_t CFG_WIDTH  = 3'd4;
    localparam cfg_idx_t CFG_HEIGHT = 3'd5;
    localparam cfg_idx_t CFG_BIND   = 3'd6;

    typedef struct packed {
        logic               mode_analog;
        logic [ACC_W-1:0]   acceleration;
        logic [SPD_W-1:0]   max_speed;
        logic [DZ_W-1:0]    dead_zone;
        logic [SCR_W-1:0]   screen_width;
        logic [SCR_W-1:0]   screen_height;
        logic [BINDS_W-1:0] bindings;
    } cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic [EV_CNT_W-1:0]                 ev_cnt;
        logic [MOUSE_BUTTONS-1:0][MB_W-1:0]  ev_mb;
        logic [MOUSE_BUTTONS-1:0]            ev_pr;
        logic                                up;
        logic                                down;
        logic                                left;
        logic                                right;
        logic [STICK_W-1:0]                  stick_x;
        logic [STICK_W-1:0]                  stick_y;
    } fe_item_t;

    typedef struct packed {
        logic              zero;
        logic              neg;
        logic [PROD_W-1:0] prod;
    } ana_t;

    typedef struct packed {
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
    } axis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_MOVE
    } back_state_t;

    function automatic logic [SCR_W-1:0] clamp_screen(input logic [SCR_W-1:0] s);
        logic [SCR_W-1:0] r;
        if (s == '0)
            r = SCR_W'(1);
        else if (s > MAX_SCREEN)
            r = MAX_SCREEN;
        else
            r = s;
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] digital_axis(
        input logic signed [VEL_W-1:0] v,
        input logic                    neg,
        input logic                    pos,
        input logic [ACC_W-1:0]        a,
        input logic [SPD_W-1:0]        m
    );
        logic signed [VEL_W+1:0] w;
        logic signed [VEL_W+1:0] sa;
        logic signed [VEL_W+1:0] sm;
        logic signed [VEL_W+1:0] zero;
        zero = '0;
        sa = $signed({{(VEL_W+2-ACC_W){1'b0}}, a});
        sm = $signed({{(VEL_W+2-SPD_W){1'b0}}, m});
        w  = (VEL_W+2)'(v);
        case ({neg, pos})
            2'b10:   w = w - sa;
            2'b01:   w = w + sa;
            2'b00:
            begin
                if (w > zero)
                    w = w - sa;
                else if (w < zero)
                    w = w + sa;
            end
            default: w = w;
        endcase
        if (w != zero && w > -sa && w < sa)
            w = zero;
        if (w > sm)
            w = sm;
        if (w < -sm)
            w = -sm;
        return w[VEL_W-1:0];
    endfunction

    function automatic ana_t analog_front(
        input logic [STICK_W-1:0] stick,
        input logic [DZ_W-1:0]    dz,
        input logic [SPD_W-1:0]   ms
    );
        logic signed [STICK_W:0]     off;
        logic [STICK_W:0]            mag9;
        logic [MAG_W-1:0]            mag;
        logic [MAG_W+SPD_W-1:0]      prod;
        ana_t                        r;
        off  = $signed({1'b0, stick}) - $signed(STICK_CENTRE);
        mag9 = off[STICK_W] ? 9'(-off) : 9'(off);
        mag  = mag9[MAG_W-1:0];
        prod = mag * ms;
        r.zero = mag < dz;
        r.neg  = off[STICK_W];
        r.prod = prod[PROD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [VEL_W-1:0] analog_div(input ana_t a);
        logic [PROD_W:0]                 p1;
        logic [PROD_W+1+RECIP_W-1:0]     full;
        logic [QUO_W-1:0]                q;
        logic signed [VEL_W-1:0]         qs;
        logic signed [VEL_W-1:0]         r;
        p1   = {1'b0, a.prod} + (PROD_W+1)'(1);
        full = p1 * RECIP;
        q    = full[RECIP_SHIFT +: QUO_W];
        qs   = $signed({1'b0, q});
        if (a.zero)
            r = '0;
        else if (a.neg)
            r = -qs;
        else
            r = qs;
        return r;
    endfunction

    function automatic axis_t move_axis(
        input logic [POS_W-1:0]        p,
        input logic signed [VEL_W-1:0] v,
        input logic [SCR_W-1:0]        lim
    );
        logic signed [POS_W+1:0] np;
        logic [POS_W:0]          limq;
        logic [SCR_W-1:0]        lim_m1;
        axis_t                   r;
        np     = $signed({2'b00, p}) + (POS_W+2)'(v);
        limq   = {lim, FRAC_BITS'(0)};
        lim_m1 = lim - SCR_W'(1);
        if (np[POS_W+1])
        begin
            r.pos = '0;
            r.vel = '0;
        end
        else if (np >= $signed({1'b0, limq}))
        begin
            r.pos = {lim_m1[COORD_W-1:0], FRAC_BITS'(0)};
            r.vel = '0;
        end
        else
        begin
            r.pos = np[POS_W-1:0];
            r.vel = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/gtp_in_if.sv
// Sample channel: valid/ready handshake with the gamepad sample payload.
// Depends on gtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gtp_in_if;
    logic                              valid;
    logic                              ready;
    logic [gtp_pkg::PAD_BUTTONS-1:0]   buttons;
    logic [gtp_pkg::STICK_W-1:0]       stick_x;
    logic [gtp_pkg::STICK_W-1:0]       stick_y;

    modport source (output valid, buttons, stick_x, stick_y, input ready);
    modport sink   (input valid, buttons, stick_x, stick_y, output ready);
endinterface

`default_nettype wire

### rtl/gtp_out_if.sv
// Result channel: valid/ready handshake with the event or position payload.
// Depends on gtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gtp_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [gtp_pkg::MB_W-1:0]      mouse_btn;
    logic                          pressed;
    logic [gtp_pkg::COORD_W-1:0]   cursor_x;
    logic [gtp_pkg::COORD_W-1:0]   cursor_y;
    logic                          last;

    modport source (output valid, kind, mouse_btn, pressed, cursor_x, cursor_y, last,
                     input ready);
    modport sink   (input valid, kind, mouse_btn, pressed, cursor_x, cursor_y, last,
                     output ready);
endinterface

`default_nettype wire

### rtl/gamepad_to_pointer_motion.sv
// Button events of a sample leave ahead of its position result; a stall on the result
// side holds both back.
// Samples queue while the back end works on the last; its pace is set by its three-step
// velocity/position sequence and the single output register shared by events and position.
// Reset (rst_n, async, active low) releases all buttons, zeroes velocity and position,
// loads the register defaults and empties the two-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_to_pointer_motion (
    input  logic                          clk,
    input  logic                          rst_n,
    gtp_in_if.sink                        sample,
    gtp_out_if.source                     result,
    input  logic                          cfg_we,
    input  gtp_pkg::cfg_idx_t             cfg_index,
    input  logic [gtp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gtp_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      q_ready;
    logic      q_push;
    fe_item_t  push_item;
    logic      q_valid;
    logic      q_pop;
    fe_item_t  pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   cfg_next.mode_analog   = cfg_data[0];
                CFG_ACCEL:  cfg_next.acceleration  = cfg_data[ACC_W-1:0];
                CFG_SPEED:  cfg_next.max_speed     = cfg_data[SPD_W-1:0];
                CFG_DEAD:   cfg_next.dead_zone     = cfg_data[DZ_W-1:0];
                CFG_WIDTH:  cfg_next.screen_width  = cfg_data[SCR_W-1:0];
                CFG_HEIGHT: cfg_next.screen_height = cfg_data[SCR_W-1:0];
                CFG_BIND:   cfg_next.bindings      = cfg_data[BINDS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_analog   <= 1'b0;
            cfg_reg.acceleration  <= ACC_W'(256);
            cfg_reg.max_speed     <= SPD_W'(2048);
            cfg_reg.dead_zone     <= DZ_W'(16);
            cfg_reg.screen_width  <= SCR_W'(480);
            cfg_reg.screen_height <= SCR_W'(272);
            cfg_reg.bindings      <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    gtp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .bindings (cfg_reg.bindings),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    gtp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    gtp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

### rtl/gtp_front.sv
// Front end: takes samples, tracks held buttons, builds the ordered event list.
// Depends on gtp_pkg and gtp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module gtp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    gtp_in_if.sink                        sample,
    input  logic [gtp_pkg::BINDS_W-1:0]   bindings,
    input  logic                          q_ready,
    output logic                          q_push,
    output gtp_pkg::fe_item_t             q_item
);
    import gtp_pkg::*;

    logic [PAD_BUTTONS-1:0] held_reg;
    logic [PAD_BUTTONS-1:0] held_next;
    logic [PAD_BUTTONS-1:0] changed;
    logic [BIND_W-1:0]      f     [MOUSE_BUTTONS];
    logic [BIND_W-1:0]      pidx  [MOUSE_BUTTONS];
    logic [EV_CNT_W-1:0]    rank  [MOUSE_BUTTONS];
    logic [MOUSE_BUTTONS-1:0] hit;
    logic [MOUSE_BUTTONS-1:0] pr;
    logic [EV_CNT_W-1:0]    cnt;

    assign sample.ready = q_ready;
    assign q_push       = sample.valid && q_ready;
    assign held_next    = q_push ? sample.buttons : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else
            held_reg <= held_next;
    end

    always_comb
    begin
        changed = sample.buttons ^ held_reg;
        cnt     = '0;
        for (int m = 0; m < MOUSE_BUTTONS; m++)
        begin
            f[m]    = bindings[m*BIND_W +: BIND_W];
            pidx[m] = f[m] - BIND_W'(1);
            hit[m]  = (f[m] != '0) && (f[m] <= BIND_W'(PAD_BUTTONS)) && changed[pidx[m]];
            pr[m]   = sample.buttons[pidx[m]];
            cnt     = cnt + EV_CNT_W'(hit[m]);
        end
        // events go out by gamepad index, then mouse index
        for (int m = 0; m < MOUSE_BUTTONS; m++)
        begin
            rank[m] = '0;
            for (int k = 0; k < MOUSE_BUTTONS; k++)
            begin
                if (hit[k] && (f[k] < f[m] || (f[k] == f[m] && k < m)))
                    rank[m] = rank[m] + EV_CNT_W'(1);
            end
        end
        q_item = '0;
        for (int s = 0; s < MOUSE_BUTTONS; s++)
        begin
            for (int m = 0; m < MOUSE_BUTTONS; m++)
            begin
                if (hit[m] && rank[m] == EV_CNT_W'(s))
                begin
                    q_item.ev_mb[s] = MB_W'(m);
                    q_item.ev_pr[s] = pr[m];
                end
            end
        end
        q_item.ev_cnt  = cnt;
        q_item.up      = sample.buttons[BTN_UP];
        q_item.down    = sample.buttons[BTN_DOWN];
        q_item.left    = sample.buttons[BTN_LEFT];
        q_item.right   = sample.buttons[BTN_RIGHT];
        q_item.stick_x = sample.stick_x;
        q_item.stick_y = sample.stick_y;
    end

endmodule

`default_nettype wire

### rtl/gtp_fifo.sv
// Two-entry queue of classified samples between front and back.
// Depends on gtp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gtp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gtp_pkg::fe_item_t  push_item,
    output logic               not_full,
    input  logic               pop,
    output logic               not_empty,
    output gtp_pkg::fe_item_t  pop_item
);
    import gtp_pkg::*;

    fe_item_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic [FIFO_CNT_W-1:0]   cnt_next;

    assign not_full  = cnt_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/gtp_back.sv
// Back end: emits button events, updates velocity and position, registers results.
// Depends on gtp_pkg, gtp_out_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "gamepad_to_pointer_motion_assert.svh"

module gtp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gtp_pkg::cfg_t      cfg,
    input  logic               q_valid,
    input  gtp_pkg::fe_item_t  q_item,
    output logic               q_pop,
    gtp_out_if.source          result
);
    import gtp_pkg::*;

    back_state_t             state_reg;
    back_state_t             state_next;
    fe_item_t                item_reg;
    logic [EV_CNT_W-1:0]     ev_idx_reg;
    logic [EV_CNT_W-1:0]     ev_idx_next;

    logic signed [VEL_W-1:0] vel_x_reg;
    logic signed [VEL_W-1:0] vel_y_reg;
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_y_reg;
    ana_t                    ana_x_reg;
    ana_t                    ana_y_reg;
    logic signed [VEL_W-1:0] vd_x_reg;
    logic signed [VEL_W-1:0] vd_y_reg;
    logic signed [VEL_W-1:0] vc_x_reg;
    logic signed [VEL_W-1:0] vc_y_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_kind_reg;
    logic [MB_W-1:0]         out_mb_reg;
    logic                    out_pr_reg;
    logic [COORD_W-1:0]      out_x_reg;
    logic [COORD_W-1:0]      out_y_reg;
    logic                    out_last_reg;

    logic                    out_free;
    logic                    ev_pend;
    logic                    ev_fire;
    logic                    move_fire;
    logic [SCR_W-1:0]        lim_x;
    logic [SCR_W-1:0]        lim_y;
    axis_t                   mv_x;
    axis_t                   mv_y;

    assign result.valid     = out_valid_reg;
    assign result.kind      = out_kind_reg;
    assign result.mouse_btn = out_mb_reg;
    assign result.pressed   = out_pr_reg;
    assign result.cursor_x  = out_x_reg;
    assign result.cursor_y  = out_y_reg;
    assign result.last      = out_last_reg;

    assign lim_x = clamp_screen(cfg.screen_width);
    assign lim_y = clamp_screen(cfg.screen_height);
    assign mv_x  = move_axis(pos_x_reg, vc_x_reg, lim_x);
    assign mv_y  = move_axis(pos_y_reg, vc_y_reg, lim_y);

    always_comb
    begin
        out_free   = !out_valid_reg || result.ready;
        ev_pend    = ev_idx_reg != item_reg.ev_cnt;
        ev_fire    = (state_reg != ST_IDLE) && ev_pend && out_free;
        move_fire  = (state_reg == ST_MOVE) && !ev_pend && out_free;
        q_pop      = q_valid && (state_reg == ST_IDLE || move_fire);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_pop) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_MOVE;
            ST_MOVE:
            begin
                if (move_fire)
                    state_next = q_pop ? ST_MUL : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (q_pop)
            ev_idx_next = '0;
        else if (ev_fire)
            ev_idx_next = ev_idx_reg + EV_CNT_W'(1);
        else
            ev_idx_next = ev_idx_reg;
        if (ev_fire || move_fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ev_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            item_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ev_idx_reg    <= ev_idx_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
                item_reg <= q_item;
            if (move_fire)
            begin
                vel_x_reg <= mv_x.vel;
                vel_y_reg <= mv_y.vel;
                pos_x_reg <= mv_x.pos;
                pos_y_reg <= mv_y.pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            vd_y_reg  <= digital_axis(vel_y_reg, item_reg.up, item_reg.down,
                                      cfg.acceleration, cfg.max_speed);
            vd_x_reg  <= digital_axis(vel_x_reg, item_reg.left, item_reg.right,
                                      cfg.acceleration, cfg.max_speed);
            ana_x_reg <= analog_front(item_reg.stick_x, cfg.dead_zone, cfg.max_speed);
            ana_y_reg <= analog_front(item_reg.stick_y, cfg.dead_zone, cfg.max_speed);
        end
        if (state_reg == ST_DIV)
        begin
            vc_x_reg <= cfg.mode_analog ? analog_div(ana_x_reg) : vd_x_reg;
            vc_y_reg <= cfg.mode_analog ? analog_div(ana_y_reg) : vd_y_reg;
        end
        if (ev_fire)
        begin
            out_kind_reg <= 1'b0;
            out_mb_reg   <= item_reg.ev_mb[ev_idx_reg];
            out_pr_reg   <= item_reg.ev_pr[ev_idx_reg];
            out_x_reg    <= pos_x_reg[POS_W-1:FRAC_BITS];
            out_y_reg    <= pos_y_reg[POS_W-1:FRAC_BITS];
            out_last_reg <= 1'b0;
        end
        else if (move_fire)
        begin
            out_kind_reg <= 1'b1;
            out_mb_reg   <= '0;
            out_pr_reg   <= 1'b0;
            out_x_reg    <= mv_x.pos[POS_W-1:FRAC_BITS];
            out_y_reg    <= mv_y.pos[POS_W-1:FRAC_BITS];
            out_last_reg <= 1'b1;
        end
    end

    `GTP_ASSERT_IMP(a_ev_idx_bound, state_reg != ST_IDLE, ev_idx_reg <= item_reg.ev_cnt)
    `GTP_ASSERT_NEXT(a_move_gives_last, move_fire, out_valid_reg && out_last_reg && out_kind_reg)
    `GTP_ASSERT_IMP(a_pos_on_screen, out_valid_reg && out_kind_reg,
                    {1'b0, out_x_reg} < lim_x && {1'b0, out_y_reg} < lim_y)

endmodule

`default_nettype wire

### sim/tb_gamepad_to_pointer_motion.sv
// Testbench for gamepad_to_pointer_motion: directed table, then random phases under
// varied idling, results checked against an in-bench predictor or a table cursor.
// Depends on gtp_pkg, gtp_in_if, gtp_out_if and the RTL top.
`timescale 1ns / 1ps

module tb_gamepad_to_pointer_motion;
    import gtp_pkg::*;

    localparam int TIMEOUT_NS  = 1_000_000;
    localparam int STICK_MID   = 127;
    localparam int SCREEN_MAX  = 1024;
    localparam int N_STEPS     = 37;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 56;

    localparam cfg_idx_t CFG_NONE = 3'd7;

    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_CURSOR = 1'b1;

    localparam logic [PAD_BUTTONS-1:0] PAD_UP    = PAD_BUTTONS'(1) << BTN_UP;
    localparam logic [PAD_BUTTONS-1:0] PAD_RIGHT = PAD_BUTTONS'(1) << BTN_RIGHT;
    localparam logic [PAD_BUTTONS-1:0] PAD_DOWN  = PAD_BUTTONS'(1) << BTN_DOWN;
    localparam logic [PAD_BUTTONS-1:0] PAD_LEFT  = PAD_BUTTONS'(1) << BTN_LEFT;
    localparam logic [PAD_BUTTONS-1:0] PAD_ALL   = '1;

    typedef struct packed {
        logic               kind;
        logic [MB_W-1:0]    mouse_btn;
        logic               pressed;
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic               last;
    } report_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CHECKED
    } row_t;

    typedef struct packed {
        row_t                  kind;
        cfg_idx_t              index;
        logic [CFG_DATA_W-1:0] data;
        logic [PAD_BUTTONS-1:0] pad;
        logic [STICK_W-1:0]    sx;
        logic [STICK_W-1:0]    sy;
        logic [COORD_W-1:0]    want_x;
        logic [COORD_W-1:0]    want_y;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic take_result = 1'b0;

    int gap_pct = 0;
    int stall_pct = 0;
    int failures = 0;

    // pointer predictor state
    cfg_t regs;
    logic [PAD_BUTTONS-1:0] held_pad;
    int vel_x, vel_y, pos_x, pos_y;
    report_t reports[$];

    gtp_in_if  sample_if ();
    gtp_out_if result_if ();

    assign result_if.ready = take_result;

    gamepad_to_pointer_motion u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    step_t steps [N_STEPS] = '{
        '{ROW_CHECKED, CFG_MODE,   0, 0,                            127, 127, 0, 0},
        '{ROW_CHECKED, CFG_MODE,   0, PAD_RIGHT | PAD_DOWN,         127, 127, 1, 1},
        '{ROW_CHECKED, CFG_MODE,   0, PAD_RIGHT | PAD_DOWN,         127, 127, 3, 3},
        '{ROW_CHECKED, CFG_MODE,   0, 0,                            127, 127, 4, 4},
        '{ROW_CHECKED, CFG_MODE,   0, PAD_UP | PAD_LEFT,            127, 127, 4, 4},
        '{ROW_CHECKED, CFG_MODE,   0, PAD_UP | PAD_LEFT,            127, 127, 3, 3},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_UP | PAD_LEFT | PAD_RIGHT, 127, 127, 0, 0},
        '{ROW_WRITE,   CFG_WIDTH,  0,     0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_HEIGHT, 2047,  0, 0, 0, 0, 0},
        '{ROW_CHECKED, CFG_MODE,   0, 0,                            127, 127, 0, 0},
        '{ROW_WRITE,   CFG_ACCEL,  4095,  0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_SPEED,  16383, 0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_WIDTH,  2047,  0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_BIND,   1 | (22 << 5) | (1 << 10), 0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_ALL,                      255, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_RIGHT,                    127, 127, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_RIGHT,                    127, 127, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_RIGHT,                    127, 127, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_RIGHT,                    127, 127, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_RIGHT,                    127, 127, 0, 0},
        '{ROW_WRITE,   CFG_BIND,   23 | (31 << 5), 0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_ALL,                      127, 127, 0, 0},
        '{ROW_WRITE,   CFG_MODE,   32767, 0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_SPEED,  2048,  0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, 0,                            255, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, 0,                            143, 111, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, 0,                            142, 112, 0, 0},
        '{ROW_WRITE,   CFG_DEAD,   128,   0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, 0,                            255, 0, 0, 0},
        '{ROW_WRITE,   CFG_DEAD,   0,     0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_SPEED,  0,     0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, 0,                            200, 50, 0, 0},
        '{ROW_WRITE,   CFG_NONE,   32767, 0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, 0,                            0, 255, 0, 0},
        '{ROW_WRITE,   CFG_ACCEL,  0,     0, 0, 0, 0, 0},
        '{ROW_WRITE,   CFG_MODE,   0,     0, 0, 0, 0, 0},
        '{ROW_SAMPLE,  CFG_MODE,   0, PAD_RIGHT,                    127, 127, 0, 0}
    };

    function automatic int steer_axis(int v, logic neg, logic pos);
        int a;
        int m;
        a = int'(regs.acceleration);
        m = int'(regs.max_speed);
        if (neg)
            v -= a;
        if (pos)
            v += a;
        if (!neg && !pos)
        begin
            if (v > 0)
                v -= a;
            else if (v < 0)
                v += a;
        end
        if (v != 0 && v > -a && v < a)
            v = 0;
        if (v > m)
            v = m;
        if (v < -m)
            v = -m;
        return v;
    endfunction

    function automatic int stick_speed(logic [STICK_W-1:0] reading);
        int off;
        int mag;
        off = int'(reading) - STICK_MID;
        mag = (off < 0) ? -off : off;
        if (mag < int'(regs.dead_zone))
            return 0;
        return (off * int'(regs.max_speed)) / STICK_MID;
    endfunction

    task automatic glide(inout int p, inout int v, input logic [SCR_W-1:0] size);
        int lim;
        if (size == 0)
            lim = 1;
        else if (int'(size) > SCREEN_MAX)
            lim = SCREEN_MAX;
        else
            lim = int'(size);
        p = p + v;
        if (p < 0)
        begin
            p = 0;
            v = 0;
        end
        if (p >= (lim << FRAC_BITS))
        begin
            p = (lim - 1) << FRAC_BITS;
            v = 0;
        end
    endtask

    function automatic report_t make_report(logic kind, int mb, logic pressed, logic last);
        report_t r;
        r.kind      = kind;
        r.mouse_btn = MB_W'(mb);
        r.pressed   = pressed;
        r.cursor_x  = COORD_W'(pos_x >> FRAC_BITS);
        r.cursor_y  = COORD_W'(pos_y >> FRAC_BITS);
        r.last      = last;
        return r;
    endfunction

    // queues the button events of one sample and hands back its cursor report
    task automatic predict_sample(input logic [PAD_BUTTONS-1:0] pad,
                                  input logic [STICK_W-1:0] sx,
                                  input logic [STICK_W-1:0] sy,
                                  output report_t cursor);
        logic [PAD_BUTTONS-1:0] changed;
        logic [BIND_W-1:0] bind_field;
        int i;
        int m;
        changed = pad ^ held_pad;
        for (i = 0; i < PAD_BUTTONS; i++)
        begin
            if (changed[i])
            begin
                for (m = 0; m < MOUSE_BUTTONS; m++)
                begin
                    bind_field = regs.bindings[BIND_W*m +: BIND_W];
                    if (bind_field != 0 && int'(bind_field) - 1 == i)
                        reports.push_back(make_report(KIND_BUTTON, m, pad[i], 1'b0));
                end
            end
        end
        held_pad = pad;
        if (!regs.mode_analog)
        begin
            vel_y = steer_axis(vel_y, held_pad[BTN_UP], held_pad[BTN_DOWN]);
            vel_x = steer_axis(vel_x, held_pad[BTN_LEFT], held_pad[BTN_RIGHT]);
        end
        else
        begin
            vel_x = stick_speed(sx);
            vel_y = stick_speed(sy);
        end
        glide(pos_x, vel_x, regs.screen_width);
        glide(pos_y, vel_y, regs.screen_height);
        cursor = make_report(KIND_CURSOR, 0, 1'b0, 1'b1);
    endtask

    task automatic write_reg(input cfg_idx_t index, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_MODE:   regs.mode_analog   = value[0];
            CFG_ACCEL:  regs.acceleration  = value[ACC_W-1:0];
            CFG_SPEED:  regs.max_speed     = value[SPD_W-1:0];
            CFG_DEAD:   regs.dead_zone     = value[DZ_W-1:0];
            CFG_WIDTH:  regs.screen_width  = value[SCR_W-1:0];
            CFG_HEIGHT: regs.screen_height = value[SCR_W-1:0];
            CFG_BIND:   regs.bindings      = value[BINDS_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic send_sample(input logic [PAD_BUTTONS-1:0] pad,
                               input logic [STICK_W-1:0] sx,
                               input logic [STICK_W-1:0] sy,
                               input bit typed,
                               input logic [COORD_W-1:0] want_x,
                               input logic [COORD_W-1:0] want_y);
        report_t cursor;
        cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.buttons <= pad;
        sample_if.stick_x <= sx;
        sample_if.stick_y <= sy;
        do
            @(posedge clk);
        while (!sample_if.ready);
        predict_sample(pad, sx, sy, cursor);
        if (typed)
        begin
            cursor.cursor_x = want_x;
            cursor.cursor_y = want_y;
        end
        reports.push_back(cursor);
    endtask

    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (reports.size() != 0);
    endtask

    function automatic int pick_extreme(int lo, int hi, int typical);
        case ($urandom_range(0, 7))
            0, 1:    return lo;
            2, 3:    return hi;
            default: return typical;
        endcase
    endfunction

    function automatic int screen_pick();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 2047;
            2:       return 1;
            3:       return SCREEN_MAX;
            4:       return $urandom_range(2, 16);
            default: return $urandom_range(17, SCREEN_MAX);
        endcase
    endfunction

    // mostly low buttons so that bound buttons toggle often
    function automatic logic [BIND_W-1:0] bind_pick();
        if ($urandom_range(0, 3) == 0)
            return BIND_W'($urandom_range(0, 31));
        return BIND_W'($urandom_range(1, 8));
    endfunction

    function automatic logic [PAD_BUTTONS-1:0] vary_pad(logic [PAD_BUTTONS-1:0] prev);
        case ($urandom_range(0, 9))
            0:          return PAD_BUTTONS'($urandom);
            1, 2, 3, 4: return prev ^ (PAD_BUTTONS'(1) << $urandom_range(0, 7));
            5:          return prev ^ (PAD_BUTTONS'(1) << $urandom_range(0, PAD_BUTTONS - 1));
            default:    return prev;
        endcase
    endfunction

    function automatic logic [STICK_W-1:0] stick_pick();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return STICK_W'(STICK_MID + int'(regs.dead_zone));
            3:       return STICK_W'(STICK_MID + int'(regs.dead_zone) - 1);
            4:       return STICK_W'(STICK_MID - int'(regs.dead_zone));
            5:       return STICK_W'(STICK_MID);
            default: return STICK_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (reports.size() == 0)
            begin
                $error("result transfer with nothing expected");
                failures++;
            end
            else
            begin
                want = reports.pop_front();
                check_field("kind", want.kind, result_if.kind);
                check_field("mouse_btn", want.mouse_btn, result_if.mouse_btn);
                check_field("pressed", want.pressed, result_if.pressed);
                check_field("cursor_x", want.cursor_x, result_if.cursor_x);
                check_field("cursor_y", want.cursor_y, result_if.cursor_y);
                check_field("last", want.last, result_if.last);
            end
        end
        take_result <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_gamepad_to_pointer_motion NOT OK");
        $finish;
    end

    initial
    begin
        logic [PAD_BUTTONS-1:0] pad;
        int phase;
        int n;
        sample_if.valid   <= 1'b0;
        sample_if.buttons <= '0;
        sample_if.stick_x <= STICK_W'(STICK_MID);
        sample_if.stick_y <= STICK_W'(STICK_MID);
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MODE;
        cfg_data          <= '0;

        regs.mode_analog   = 1'b0;
        regs.acceleration  = 256;
        regs.max_speed     = 2048;
        regs.dead_zone     = 16;
        regs.screen_width  = 480;
        regs.screen_height = 272;
        regs.bindings      = '0;
        held_pad = '0;
        vel_x = 0;
        vel_y = 0;
        pos_x = 0;
        pos_y = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steps[k])
        begin
            if (steps[k].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(steps[k].index, steps[k].data);
            end
            else
                send_sample(steps[k].pad, steps[k].sx, steps[k].sy,
                            steps[k].kind == ROW_CHECKED, steps[k].want_x, steps[k].want_y);
        end

        pad = '0;
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            wait_drained();
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 53; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 26; stall_pct = 26; end
            endcase
            write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(CFG_ACCEL, CFG_DATA_W'(pick_extreme(0, 4095, $urandom_range(16, 600))));
            write_reg(CFG_SPEED,
                      CFG_DATA_W'(pick_extreme(0, 16383, $urandom_range(128, 4096))));
            write_reg(CFG_DEAD, CFG_DATA_W'(pick_extreme(0, 128, $urandom_range(1, 40))));
            write_reg(CFG_WIDTH, CFG_DATA_W'(screen_pick()));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(screen_pick()));
            write_reg(CFG_BIND, {bind_pick(), bind_pick(), bind_pick()});
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off the sender until the block has drained
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    wait_drained();
                pad = vary_pad(pad);
                send_sample(pad, stick_pick(), stick_pick(), 1'b0, '0, '0);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("tb_gamepad_to_pointer_motion OK");
        else
            $display("tb_gamepad_to_pointer_motion NOT OK");
        $finish;
    end

endmodule
